>>> sv/c2d_pkg.sv
// Shared types and constants for the 3x3 zero-padded convolution block.
`default_nettype none

package c2d_pkg;

    // Fixed field widths
    localparam int PIX_W  = 8;
    localparam int COEF_W = 16;
    localparam int PROD_W = 24;
    localparam int CSUM_W = 26;
    localparam int SUM_W  = 28;
    localparam int IDX_W  = 10;
    localparam int CFG_W  = 64;
    localparam int ADDR_W = 5;

    // Output queue
    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // Register map (index = paddr[4:3])
    localparam logic [1:0] REG_WIDTH    = 2'd0;
    localparam logic [1:0] REG_COEF_TOP = 2'd1;
    localparam logic [1:0] REG_COEF_MID = 2'd2;
    localparam logic [1:0] REG_COEF_BOT = 2'd3;

    localparam logic [10:0] WIDTH_RST = 11'd1024;

    typedef logic [PIX_W-1:0]         t_pix;
    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [CSUM_W-1:0] t_csum;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef logic [IDX_W-1:0]         t_idx;
    typedef logic [FIFO_CW-1:0]       t_cnt;

    // One window column, index 0 is the top row
    typedef logic [2:0][PIX_W-1:0]  t_col;
    // One kernel column, index 0 is the top row
    typedef logic [2:0][COEF_W-1:0] t_coef_col;

    // Per-item control carried down the pipeline
    typedef struct packed {
        logic v;
        logic res1_v;
        logic res2_v;
        logic drop_top;
        logic drop_l1;
        logic drop_l2;
        t_idx row;
        t_idx col;
    } t_ctl;

    // One result word
    typedef struct packed {
        t_sum value;
        t_idx row;
        t_idx col;
        logic run_end;
    } t_res;

endpackage

`default_nettype wire

>>> sv/c2d_in_if.sv
// Input pixel channel.
`default_nettype none

interface c2d_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] pixel_value;

    modport source (output valid, output req_type, output pixel_value, input ready);
    modport sink   (input valid, input req_type, input pixel_value, output ready);
endinterface

`default_nettype wire

>>> sv/c2d_out_if.sv
// Output result channel.
`default_nettype none

interface c2d_out_if;
    logic               valid;
    logic               ready;
    logic signed [27:0] filtered_value;
    logic [9:0]         out_row;
    logic [9:0]         out_col;
    logic               run_end;

    modport source (output valid, output filtered_value, output out_row, output out_col,
                    output run_end, input ready);
    modport sink   (input valid, input filtered_value, input out_row, input out_col,
                    input run_end, output ready);
endinterface

`default_nettype wire

>>> sv/c2d_cell.sv
// Window column cell: holds one column, passes it left, forms two weighted column sums.
`default_nettype none

module c2d_cell import c2d_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_shift,
    input  wire t_col      i_col,
    output t_col           o_col,
    input  wire t_coef_col i_coef_a,
    input  wire t_coef_col i_coef_b,
    input  wire logic      i_drop_top,
    output t_csum          o_sum_a,
    output t_csum          o_sum_b
);

    t_col  r_col;
    t_prod r_prod_a [3];
    t_prod r_prod_b [3];
    t_csum r_sum_a;
    t_csum r_sum_b;

    // Column register, shifts on each new item
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_col <= i_col;
        end
    end

    assign o_col = r_col;

    // Products, top row dropped at the top image edge
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            if (i == 0 && i_drop_top) begin
                r_prod_a[i] <= '0;
                r_prod_b[i] <= '0;
            end else begin
                r_prod_a[i] <= t_prod'($signed(i_coef_a[i]))
                             * t_prod'($signed({1'b0, r_col[i]}));
                r_prod_b[i] <= t_prod'($signed(i_coef_b[i]))
                             * t_prod'($signed({1'b0, r_col[i]}));
            end
        end
    end

    // Column sums
    always_ff @(posedge i_clk) begin
        r_sum_a <= t_csum'(r_prod_a[0]) + t_csum'(r_prod_a[1]) + t_csum'(r_prod_a[2]);
        r_sum_b <= t_csum'(r_prod_b[0]) + t_csum'(r_prod_b[1]) + t_csum'(r_prod_b[2]);
    end

    assign o_sum_a = r_sum_a;
    assign o_sum_b = r_sum_b;

endmodule

`default_nettype wire

>>> sv/c2d_out_fifo.sv
// Output queue taking up to two result words per cycle and draining one when ready.
`default_nettype none

module c2d_out_fifo import c2d_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push_a,
    input  wire t_res  i_data_a,
    input  wire logic  i_push_b,
    input  wire t_res  i_data_b,
    output t_cnt       o_count,
    c2d_out_if.source  o_res
);

    t_res               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr;
    logic [FIFO_AW-1:0] r_rd;
    t_cnt               r_count;
    logic               w_pop;
    logic [FIFO_AW-1:0] w_wr_b;

    assign w_pop  = o_res.valid && o_res.ready;
    assign w_wr_b = r_wr + FIFO_AW'(i_push_a);

    // Storage writes
    always_ff @(posedge i_clk) begin
        if (i_push_a) begin
            r_mem[r_wr] <= i_data_a;
        end
        if (i_push_b) begin
            r_mem[w_wr_b] <= i_data_b;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + FIFO_AW'(i_push_a) + FIFO_AW'(i_push_b);
            r_rd    <= r_rd + FIFO_AW'(w_pop);
            r_count <= r_count + t_cnt'(i_push_a) + t_cnt'(i_push_b) - t_cnt'(w_pop);
        end
    end

    // Head word
    assign o_count              = r_count;
    assign o_res.valid          = (r_count != '0);
    assign o_res.filtered_value = r_mem[r_rd].value;
    assign o_res.out_row        = r_mem[r_rd].row;
    assign o_res.out_col        = r_mem[r_rd].col;
    assign o_res.run_end        = r_mem[r_rd].run_end;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_cnt'(FIFO_DEPTH))
        else $error("output queue count past depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_count) + 32'(i_push_a) + 32'(i_push_b) <= FIFO_DEPTH))
        else $error("output queue overflow");

    a_empty_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 && !i_push_a && !i_push_b) |=> !o_res.valid)
        else $error("output valid without a stored word");

endmodule

`default_nettype wire

>>> sv/conv2d_3x3_zero_pad.sv
// Result path: line-store read, cell column, product, column-sum registers, queue.
// Throughput: one input word per cycle while ready is high; a row-end word past the
// first row yields two results, the extra one is absorbed by a 16-entry output queue
// and drained at one word per cycle while the receiver is ready. Ready drops only
// when the queue plus the 4 in-flight stages could overflow it. Reset: row/column
// counters clear, width returns to 1024, coefficients to zero; line store kept.
`default_nettype none

module conv2d_3x3_zero_pad import c2d_pkg::*; #(
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_HEIGHT  = 1024,
    parameter int KERNEL_SIZE = 3
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    c2d_in_if.sink                 i_pix,
    c2d_out_if.source              o_res,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [CFG_W-1:0]  pwdata,
    output logic [CFG_W-1:0]       prdata,
    output logic                   pready
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT + 1);
    localparam int KC = KERNEL_SIZE;

    // Configuration registers
    logic [10:0] r_width;
    logic [47:0] r_coef_top;
    logic [47:0] r_coef_mid;
    logic [47:0] r_coef_bot;

    // Stream state
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [CW-1:0] n_col;
    logic [RW-1:0] n_row;

    // Line store: [15:8] previous row, [7:0] row before it
    logic [15:0]   r_mem [MAX_WIDTH];
    logic [15:0]   r_rd;
    t_pix          r_p1_px;
    logic [CW-1:0] r_p1_addr;

    t_ctl r_p1, r_p2, r_p3, r_p4;
    t_ctl n_p1;

    logic          w_acc;
    logic          w_wr;
    t_pix          w_px;
    logic [CW-1:0] w_last;
    logic          w_row_end;
    logic [2:0]    w_inflight;
    logic [5:0]    w_need;
    t_cnt          w_count;

    t_col      w_col    [KC+1];
    t_coef_col w_coef   [KC];
    t_coef_col w_coef_b [KC];
    t_csum     w_sum_a  [KC];
    t_csum     w_sum_b  [KC];

    t_sum w_res1;
    t_sum w_res2;
    t_res w_data_a;
    t_res w_data_b;

    // APB write decode
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= WIDTH_RST;
            r_coef_top <= '0;
            r_coef_mid <= '0;
            r_coef_bot <= '0;
        end else if (w_wr) begin
            case (paddr[4:3])
                REG_WIDTH:    r_width    <= pwdata[10:0];
                REG_COEF_TOP: r_coef_top <= pwdata[47:0];
                REG_COEF_MID: r_coef_mid <= pwdata[47:0];
                REG_COEF_BOT: r_coef_bot <= pwdata[47:0];
                default:      r_width    <= r_width;
            endcase
        end
    end

    // APB read mux
    always_comb begin
        case (paddr[4:3])
            REG_WIDTH:    prdata = CFG_W'(r_width);
            REG_COEF_TOP: prdata = CFG_W'(r_coef_top);
            REG_COEF_MID: prdata = CFG_W'(r_coef_mid);
            REG_COEF_BOT: prdata = CFG_W'(r_coef_bot);
            default:      prdata = '0;
        endcase
    end

    // Last column of a row, width clamped to [3, MAX_WIDTH]
    always_comb begin
        if (r_width < 11'd3) begin
            w_last = CW'(2);
        end else if (32'(r_width) > MAX_WIDTH) begin
            w_last = CW'(MAX_WIDTH - 1);
        end else begin
            w_last = CW'(r_width - 11'd1);
        end
    end

    // Input credit: room for two words per item in flight plus this one
    assign w_inflight  = 3'(r_p1.v) + 3'(r_p2.v) + 3'(r_p3.v) + 3'(r_p4.v);
    assign w_need      = 6'(w_count) + 6'({w_inflight, 1'b0});
    assign i_pix.ready = (w_need <= 6'(FIFO_DEPTH - 2));
    assign w_acc       = i_pix.valid && i_pix.ready;

    assign w_px      = i_pix.req_type ? '0 : i_pix.pixel_value;
    assign w_row_end = (r_col >= w_last);

    // Counter update and stage-1 control
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (w_acc) begin
            if (w_row_end) begin
                n_col = '0;
                if (i_pix.req_type) begin
                    n_row = '0;
                end else if (32'(r_row) < MAX_HEIGHT) begin
                    n_row = r_row + RW'(1);
                end
            end else begin
                n_col = r_col + CW'(1);
            end
        end
        n_p1          = '0;
        n_p1.v        = w_acc;
        n_p1.res1_v   = (r_row != '0) && (r_col != '0);
        n_p1.res2_v   = w_row_end && (r_row != '0);
        n_p1.drop_top = (r_row == RW'(1));
        n_p1.drop_l1  = (r_col == CW'(1));
        n_p1.drop_l2  = (r_col == '0);
        n_p1.row      = t_idx'(r_row - RW'(1));
        n_p1.col      = t_idx'(r_col);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_p1  <= '0;
            r_p2  <= '0;
            r_p3  <= '0;
            r_p4  <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            r_p1  <= n_p1;
            r_p2  <= r_p1;
            r_p3  <= r_p2;
            r_p4  <= r_p3;
        end
    end

    // Line store: read on accept, write back from the stage-1 registers
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_rd      <= r_mem[r_col];
            r_p1_px   <= w_px;
            r_p1_addr <= r_col;
        end
        if (r_p1.v) begin
            r_mem[r_p1_addr] <= {r_p1_px, r_rd[15:8]};
        end
    end

    // New window column entering the cell chain
    always_comb begin
        w_col[KC]    = '0;
        w_col[KC][0] = r_rd[7:0];
        w_col[KC][1] = r_rd[15:8];
        w_col[KC][2] = r_p1_px;
    end

    // Kernel columns; b weights are shifted one column right, cell 0 gets none
    always_comb begin
        for (int j = 0; j < KC; j++) begin
            w_coef[j][0] = r_coef_top[16*j +: 16];
            w_coef[j][1] = r_coef_mid[16*j +: 16];
            w_coef[j][2] = r_coef_bot[16*j +: 16];
        end
        w_coef_b[0] = '0;
        for (int j = 1; j < KC; j++) begin
            w_coef_b[j] = w_coef[j-1];
        end
    end

    // Cell chain: cell 0 is the left window column
    for (genvar k = 0; k < KC; k++) begin : g_cell
        c2d_cell u_cell (
            .i_clk      (i_clk),
            .i_shift    (r_p1.v),
            .i_col      (w_col[k+1]),
            .o_col      (w_col[k]),
            .i_coef_a   (w_coef[k]),
            .i_coef_b   (w_coef_b[k]),
            .i_drop_top (r_p2.drop_top),
            .o_sum_a    (w_sum_a[k]),
            .o_sum_b    (w_sum_b[k])
        );
    end

    // Window totals; right column of the row-end result is padding
    assign w_res1 = (r_p4.drop_l1 ? t_sum'(0) : t_sum'(w_sum_a[0]))
                  + t_sum'(w_sum_a[1]) + t_sum'(w_sum_a[2]);
    assign w_res2 = t_sum'(w_sum_b[0])
                  + (r_p4.drop_l2 ? t_sum'(0) : t_sum'(w_sum_b[1]))
                  + t_sum'(w_sum_b[2]);

    always_comb begin
        w_data_a.value   = w_res1;
        w_data_a.row     = r_p4.row;
        w_data_a.col     = r_p4.col - t_idx'(1);
        w_data_a.run_end = !r_p4.res2_v;
        w_data_b.value   = w_res2;
        w_data_b.row     = r_p4.row;
        w_data_b.col     = r_p4.col;
        w_data_b.run_end = 1'b1;
    end

    c2d_out_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_a (r_p4.v && r_p4.res1_v),
        .i_data_a (w_data_a),
        .i_push_b (r_p4.v && r_p4.res2_v),
        .i_data_b (w_data_b),
        .o_count  (w_count),
        .o_res    (o_res)
    );

    a_enter_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && i_pix.ready) |=> r_p1.v)
        else $error("accepted word missing from stage one");

    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_row) <= MAX_HEIGHT)
        else $error("row counter past limit");

    a_col_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_row_end) |=> (r_col == '0))
        else $error("column counter did not wrap at row end");

endmodule

`default_nettype wire

>>> tb/sv/conv2d_3x3_zero_pad_tb.sv
// Self-checking testbench for the streaming 3x3 zero-padded convolution block.
`default_nettype none

module conv2d_3x3_zero_pad_tb;
    import c2d_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IMG_MAX_W   = 1024;
    localparam int IMG_MAX_H   = 1024;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RAND_WORDS  = 950;
    localparam int SETTLE      = 8;

    // One pixel-channel word waiting to be driven
    typedef struct {
        logic pad;
        t_pix px;
    } t_pix_word;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [CFG_W-1:0]   pwdata;
    logic [CFG_W-1:0]   prdata;
    logic               pready;

    c2d_in_if  pix_if ();
    c2d_out_if res_if ();

    conv2d_3x3_zero_pad uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    // Stimulus and scoreboard storage
    t_pix_word pending_words [$];
    t_res      filtered_q [$];
    bit        word_live;
    int        gen_words;
    int        mismatch_cnt;
    int        cycle_cnt;

    // Shadow of the block: configuration, line stores, window, counters
    logic [10:0] cfg_width = WIDTH_RST;
    logic [47:0] kern_row [3] = '{default: '0};
    t_pix        line_up  [IMG_MAX_W] = '{default: '0};
    t_pix        line_up2 [IMG_MAX_W] = '{default: '0};
    t_col        win_left;
    t_col        win_mid;
    int          row_cnt;
    int          col_cnt;

    // Sender burst and receiver stall state
    int          burst_left;
    int          gap_left;
    logic [15:0] stall_pat;
    int          stall_phase;

    function automatic int eff_width(logic [10:0] w);
        if (w < 3)
            return 3;
        if (w > IMG_MAX_W)
            return IMG_MAX_W;
        return int'(w);
    endfunction

    function automatic int tap(int i, int j);
        return int'(t_coef'(kern_row[i][16*j +: 16]));
    endfunction

    // Exact weighted sum over the window, columns given top row first
    function automatic t_sum window_sum(t_col lc, t_col mc, t_col rc,
                                        bit no_left, bit no_top, bit no_right);
        int acc;
        acc = 0;
        for (int i = 0; i < 3; i++) begin
            if (!(i == 0 && no_top)) begin
                if (!no_left)
                    acc += tap(i, 0) * int'(lc[i]);
                acc += tap(i, 1) * int'(mc[i]);
                if (!no_right)
                    acc += tap(i, 2) * int'(rc[i]);
            end
        end
        return acc[SUM_W-1:0];
    endfunction

    // Advance the shadow by one accepted word and queue the results it causes
    function automatic void conv_predict(logic pad, t_pix px_in);
        t_pix px;
        int   w;
        int   c;
        int   orow;
        t_col ncol;
        bit   row_end;
        t_res hits [2];
        int   n;
        px   = pad ? t_pix'(0) : px_in;
        w    = eff_width(cfg_width);
        c    = (col_cnt >= IMG_MAX_W) ? IMG_MAX_W - 1 : col_cnt;
        orow = row_cnt - 1;
        n    = 0;

        ncol[0]     = line_up2[c];
        ncol[1]     = line_up[c];
        ncol[2]     = px;
        line_up2[c] = ncol[1];
        line_up[c]  = px;

        // centered pixel one row up, one column left
        if (row_cnt >= 1 && c >= 1) begin
            hits[n] = '{value: window_sum(win_left, win_mid, ncol, c == 1, orow == 0, 1'b0),
                        row: t_idx'(orow), col: t_idx'(c - 1), run_end: 1'b0};
            n++;
        end
        win_left = win_mid;
        win_mid  = ncol;

        // row end flushes the last pixel of the row with a zero right column
        row_end = (c >= w - 1);
        if (row_end && row_cnt >= 1) begin
            hits[n] = '{value: window_sum(win_left, win_mid, '0, c == 0, orow == 0, 1'b1),
                        row: t_idx'(orow), col: t_idx'(c), run_end: 1'b0};
            n++;
        end
        if (n > 0)
            hits[n-1].run_end = 1'b1;
        for (int k = 0; k < n; k++)
            filtered_q.push_back(hits[k]);

        if (row_end) begin
            col_cnt = 0;
            if (pad)
                row_cnt = 0;
            else if (row_cnt < IMG_MAX_H)
                row_cnt++;
        end else begin
            col_cnt = c + 1;
        end
    endfunction

    // Pixel driver: bursts with random gaps, words change on the falling edge
    always @(negedge i_clk) begin
        t_pix_word w;
        if (i_rst_n && !word_live) begin
            if (gap_left > 0) begin
                gap_left--;
                pix_if.valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
                w = pending_words.pop_front();
                pix_if.valid       <= 1'b1;
                pix_if.req_type    <= w.pad;
                pix_if.pixel_value <= w.px;
                word_live = 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else if ($urandom_range(0, 7) == 0) begin
                    // long stretch without gaps
                    burst_left = $urandom_range(40, 120);
                    gap_left   = 0;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                end
            end else begin
                pix_if.valid <= 1'b0;
            end
        end

        // Result stall pattern, reloaded each time its phase wraps
        if (stall_phase == 0) begin
            case ($urandom_range(0, 3))
                0:       stall_pat = '1;
                1:       stall_pat = 16'($urandom);
                2:       stall_pat = 16'($urandom | $urandom);
                default: stall_pat = 16'($urandom & $urandom);
            endcase
        end
        res_if.ready <= stall_pat[stall_phase];
        stall_phase = (stall_phase + 1) % 16;
    end

    // Monitor: check results against the oldest expectation, then predict
    always @(posedge i_clk) begin
        t_res seen;
        t_res want;
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
            $display("Mismatches found");
            $finish;
        end else if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                seen = '{value: res_if.filtered_value, row: res_if.out_row,
                         col: res_if.out_col, run_end: res_if.run_end};
                if (filtered_q.size() == 0) begin
                    mismatch_cnt++;
                    $display("%0t: unexpected word: expected none, got value=%0d row=%0d",
                             $time, seen.value, seen.row);
                    $display("    col=%0d end=%0b", seen.col, seen.run_end);
                end else begin
                    want = filtered_q.pop_front();
                    if (seen.value !== want.value || seen.row !== want.row ||
                        seen.col !== want.col || seen.run_end !== want.run_end) begin
                        mismatch_cnt++;
                        $display("%0t: mismatch: expected value=%0d row=%0d col=%0d end=%0b",
                                 $time, want.value, want.row, want.col, want.run_end);
                        $display("    actual value=%0d row=%0d col=%0d end=%0b",
                                 seen.value, seen.row, seen.col, seen.run_end);
                    end
                end
            end
            if (pix_if.valid && pix_if.ready) begin
                conv_predict(pix_if.req_type, pix_if.pixel_value);
                word_live = 1'b0;
            end
        end
    end

    task automatic push_word(logic pad, t_pix px);
        pending_words.push_back('{pad: pad, px: px});
        gen_words++;
    endtask

    function automatic t_pix rand_pixel();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return t_pix'($urandom);
    endfunction

    function automatic logic [47:0] rand_kernel_row();
        logic [47:0] r;
        logic [15:0] picks [4] = '{16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000};
        for (int j = 0; j < 3; j++) begin
            if ($urandom_range(0, 7) == 0)
                r[16*j +: 16] = picks[$urandom_range(0, 3)];
            else
                r[16*j +: 16] = 16'($urandom);
        end
        return r;
    endfunction

    // Block has drained: nothing queued, offered or outstanding, plus latency
    task automatic wait_idle();
        while (pending_words.size() != 0 || word_live || filtered_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Two-phase register write; the shadow follows at the write edge
    task automatic reg_write(logic [1:0] idx, logic [CFG_W-1:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_WIDTH:    cfg_width   = val[10:0];
            REG_COEF_TOP: kern_row[0] = val[47:0];
            REG_COEF_MID: kern_row[1] = val[47:0];
            REG_COEF_BOT: kern_row[2] = val[47:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_kernel(logic [47:0] top, logic [47:0] mid, logic [47:0] bot);
        reg_write(REG_COEF_TOP, CFG_W'(top));
        reg_write(REG_COEF_MID, CFG_W'(mid));
        reg_write(REG_COEF_BOT, CFG_W'(bot));
    endtask

    // Queue one row; mixed flips the kind of some words, shrink narrows mid-row
    task automatic send_row(logic pad_row, bit mixed, int shrink_at, logic [10:0] shrink_to);
        int   c;
        bit   last;
        logic kind;
        c = 0;
        forever begin
            last = (c >= eff_width(cfg_width) - 1);
            kind = pad_row;
            if (mixed && $urandom_range(0, last ? 7 : 15) == 0)
                kind = !pad_row;
            push_word(kind, rand_pixel());
            if (last)
                break;
            c++;
            if (c == shrink_at) begin
                wait_idle();
                reg_write(REG_WIDTH, CFG_W'(shrink_to));
            end
        end
    endtask

    initial begin
        int          nrows;
        int          w;
        int          shrink_at;
        int          rand_start;
        logic [10:0] nw;

        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        pix_if.valid       = 1'b0;
        pix_if.req_type    = 1'b0;
        pix_if.pixel_value = '0;
        res_if.ready       = 1'b0;
        word_live          = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Largest sum: full positive kernel over a saturated 3x3 image
        reg_write(REG_WIDTH, CFG_W'(3));
        set_kernel({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}});
        repeat (9) push_word(1'b0, 8'hFF);
        repeat (3) push_word(1'b1, 8'hFF);
        wait_idle();

        // Smallest sum: full negative kernel
        set_kernel({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}});
        repeat (9) push_word(1'b0, 8'hFF);
        repeat (3) push_word(1'b1, 8'h00);

        // Padding row with no image rows before it
        repeat (3) push_word(1'b1, rand_pixel());
        wait_idle();

        // Width above the maximum clamps; row 1 is cut short by a narrowing write
        set_kernel(rand_kernel_row(), rand_kernel_row(), rand_kernel_row());
        reg_write(REG_WIDTH, CFG_W'(11'h7FF));
        send_row(1'b0, 1'b0, 0, '0);
        send_row(1'b0, 1'b0, 6, 11'd0);
        send_row(1'b0, 1'b0, 0, '0);
        send_row(1'b1, 1'b0, 0, '0);

        // Random frames: mostly well-formed with some mixed rows and noise
        rand_start = gen_words;
        while (gen_words - rand_start < RAND_WORDS) begin
            if ($urandom_range(0, 1) == 0) begin
                wait_idle();
                if ($urandom_range(0, 1) == 0) begin
                    case ($urandom_range(0, 19))
                        0:       nw = 11'($urandom_range(0, 2));
                        1, 2:    nw = 11'($urandom_range(17, 48));
                        default: nw = 11'($urandom_range(3, 10));
                    endcase
                    // inside a frame the width may only narrow
                    if (row_cnt != 0 && eff_width(nw) > eff_width(cfg_width))
                        nw = cfg_width;
                    reg_write(REG_WIDTH, CFG_W'(nw));
                end
                if ($urandom_range(0, 1) == 0)
                    reg_write(REG_COEF_TOP, CFG_W'(rand_kernel_row()));
                if ($urandom_range(0, 1) == 0)
                    reg_write(REG_COEF_MID, CFG_W'(rand_kernel_row()));
                if ($urandom_range(0, 1) == 0)
                    reg_write(REG_COEF_BOT, CFG_W'(rand_kernel_row()));
            end
            nrows = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
            for (int r = 0; r < nrows; r++) begin
                w = eff_width(cfg_width);
                shrink_at = 0;
                if (r >= 1 && w >= 4 && $urandom_range(0, 11) == 0)
                    shrink_at = $urandom_range(1, w - 2);
                send_row(1'b0, 1'b1, shrink_at, 11'($urandom_range(0, w - 1)));
            end
            send_row(1'b1, 1'b1, 0, '0);
        end

        // Tall frame: row counter saturates and rows past the limit repeat the last index
        wait_idle();
        reg_write(REG_WIDTH, CFG_W'(3));
        set_kernel(rand_kernel_row(), rand_kernel_row(), rand_kernel_row());
        repeat (IMG_MAX_H + 2) send_row(1'b0, 1'b0, 0, '0);
        send_row(1'b1, 1'b0, 0, '0);

        wait_idle();
        if (mismatch_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire
